@@ rtl/core/crg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and codes of the camera ray generation block.
package crg_pkg;

  localparam int unsigned IMAGE_WIDTH_DEF  = 1024;
  localparam int unsigned IMAGE_HEIGHT_DEF = 512;

  localparam int unsigned PIX_X_W   = 10;
  localparam int unsigned PIX_Y_W   = 9;
  localparam int unsigned CFG_W     = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COMP_W    = 16;
  localparam int unsigned FRAC_W    = 14;
  localparam int unsigned QF_W      = 15;   // unsigned coordinate factor before the offset
  localparam int unsigned FACT_W    = 16;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned MAG_W     = 31;
  localparam int unsigned SHAMT_W   = 5;
  localparam int unsigned NORM_MSB  = 29;
  localparam int unsigned SQ_W      = 62;
  localparam int unsigned PSUM_W    = 63;
  localparam int unsigned RAD_W     = 64;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned REM_W     = 34;
  localparam int unsigned NUM_W     = 46;
  localparam int unsigned DEN_W     = 47;
  localparam int unsigned QUO_W     = 15;
  localparam int unsigned DIR_W     = 16;

  localparam logic [QUO_W-1:0]         QUO_MAX  = 15'd16384;
  localparam logic signed [FACT_W-1:0] FACT_ONE = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORWARD = 2'd0,
    REG_RIGHT   = 2'd1,
    REG_UP      = 2'd2
  } crg_reg_e;

  // Component 0 is x (bits 15..0), 1 is y, 2 is z.
  typedef logic [2:0][COMP_W-1:0] crg_vec3_t;

  typedef struct packed {
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
  } crg_pix_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } crg_dir_t;

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } crg_sign_t;

  typedef struct packed {
    crg_sign_t                 sgn;
    logic [2:0][MAG_W-1:0]     mag;
  } crg_norm_t;

endpackage

@@ rtl/core/crg_isqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module crg_isqrt
  import crg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  crg_norm_t         norm_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output crg_norm_t         norm_o
);

  logic              valid_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q   [ROOT_W];
  logic [REM_W-1:0]  rem_q   [ROOT_W];
  logic [ROOT_W-1:0] root_q  [ROOT_W];
  crg_norm_t         norm_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic              prev_valid;
    logic [RAD_W-1:0]  prev_rad;
    logic [REM_W-1:0]  prev_rem;
    logic [ROOT_W-1:0] prev_root;
    crg_norm_t         prev_norm;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign prev_valid = valid_i;
      assign prev_rad   = rad_i;
      assign prev_rem   = '0;
      assign prev_root  = '0;
      assign prev_norm  = norm_i;
    end else begin : g_next
      assign prev_valid = valid_q[k-1];
      assign prev_rad   = rad_q[k-1];
      assign prev_rem   = rem_q[k-1];
      assign prev_root  = root_q[k-1];
      assign prev_norm  = norm_q[k-1];
    end

    // Bring down the next two radicand bits and try 4*root+1.
    assign cur   = {prev_rem, prev_rad[RAD_W-1 -: 2]};
    assign trial = (REM_W+2)'({prev_root, 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= prev_rad << 2;
        rem_q[k]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
        root_q[k] <= {prev_root[ROOT_W-2:0], ge};
        norm_q[k] <= prev_norm;
      end
    end
  end

  assign valid_o = valid_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign norm_o  = norm_q[ROOT_W-1];

endmodule

@@ rtl/core/crg_div.sv @@
`timescale 1ns / 1ps
// Pipelined rounding divider: three lanes of magnitude * 2^14 / root, one bit per stage.
module crg_div
  import crg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [ROOT_W-1:0]     root_i,
  input  crg_norm_t             norm_i,
  output logic                  valid_o,
  output logic [2:0][QUO_W-1:0] quo_o,
  output crg_sign_t             sgn_o
);

  logic                  valid_q [QUO_W+1];
  logic [ROOT_W-1:0]     root_q  [QUO_W+1];
  logic [2:0][NUM_W-1:0] rem_q   [QUO_W+1];
  logic [2:0][QUO_W-1:0] quo_q   [QUO_W+1];
  crg_sign_t             sgn_q   [QUO_W+1];

  logic [2:0][NUM_W-1:0] num;

  // Numerator with half the divisor added, so the floor quotient rounds.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'({norm_i.mag[i], {FRAC_W{1'b0}}}) + NUM_W'(root_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q[0] <= root_i;
      rem_q[0]  <= num;
      quo_q[0]  <= '0;
      sgn_q[0]  <= norm_i.sgn;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [DEN_W-1:0]      den;
    logic [2:0]            ge;
    logic [2:0][NUM_W-1:0] rem_n;

    assign den = DEN_W'(root_q[k-1]) << (QUO_W - k);

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i]    = (DEN_W'(rem_q[k-1][i]) >= den);
        rem_n[i] = ge[i] ? NUM_W'(DEN_W'(rem_q[k-1][i]) - den) : rem_q[k-1][i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= root_q[k-1];
        rem_q[k]  <= rem_n;
        sgn_q[k]  <= sgn_q[k-1];
        for (int i = 0; i < 3; i++) begin
          quo_q[k][i] <= {quo_q[k-1][i][QUO_W-2:0], ge[i]};
        end
      end
    end
  end

  assign valid_o = valid_q[QUO_W];
  assign quo_o   = quo_q[QUO_W];
  assign sgn_o   = sgn_q[QUO_W];

endmodule

@@ rtl/core/camera_ray_generation.sv @@
`timescale 1ns / 1ps
// Pinhole camera primary ray generation: pixel coordinate in, unit ray direction out.
//
// Input channel: in_valid_i / in_stall_o carry one pixel coordinate per beat. A
// coordinate beyond the image is clamped to the last column or row.
// Output channel: out_valid_o / out_stall_i carry one Q1.14 unit direction per beat.
// Configuration: cfg_we_i writes cfg_wdata_i into the register cfg_idx_i selects
// (forward, right scaled, up scaled); an unknown index is dropped. Write only while
// no beats are in flight.
// Throughput: one beat per cycle while the skid register is empty. An input beat reaches
// the output through nine arithmetic stages, the 32-stage square root, the 16-stage
// divider and the output register.
// Stall: the pipeline advances as one; an output register and a skid register sit
// at the end, so a stalled receiver costs nothing until both hold a beat, and then
// in_stall_o rises (it comes straight from a flop).
// Reset: clears the configuration to zero, which gives zero directions, and empties
// the pipeline.
module camera_ray_generation
  import crg_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int unsigned IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  crg_pix_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output crg_dir_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Division by the image size through a reciprocal that is exact for every
  // numerator coord * 2^15.
  localparam int unsigned X_NUM_W = PIX_X_W + QF_W;
  localparam int unsigned X_LOG   = $clog2(IMAGE_WIDTH);
  localparam int unsigned X_SHIFT = X_NUM_W + X_LOG;
  localparam int unsigned X_RCP_W = X_NUM_W + 1;
  localparam int unsigned X_PRD_W = PIX_X_W + X_RCP_W;
  localparam int unsigned X_LSB   = PIX_X_W + X_LOG;
  localparam logic [X_RCP_W-1:0] X_RECIP =
      X_RCP_W'(((64'd1 << X_SHIFT) + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH));

  localparam int unsigned Y_NUM_W = PIX_Y_W + QF_W;
  localparam int unsigned Y_LOG   = $clog2(IMAGE_HEIGHT);
  localparam int unsigned Y_SHIFT = Y_NUM_W + Y_LOG;
  localparam int unsigned Y_RCP_W = Y_NUM_W + 1;
  localparam int unsigned Y_PRD_W = PIX_Y_W + Y_RCP_W;
  localparam int unsigned Y_LSB   = PIX_Y_W + Y_LOG;
  localparam logic [Y_RCP_W-1:0] Y_RECIP =
      Y_RCP_W'(((64'd1 << Y_SHIFT) + 64'(IMAGE_HEIGHT) - 64'd1) / 64'(IMAGE_HEIGHT));

  // Configuration
  crg_vec3_t cfg_fwd_q, cfg_right_q, cfg_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_fwd_q   <= '0;
      cfg_right_q <= '0;
      cfg_up_q    <= '0;
    end else if (cfg_we_i) begin
      case (crg_reg_e'(cfg_idx_i))
        REG_FORWARD: cfg_fwd_q   <= crg_vec3_t'(cfg_wdata_i);
        REG_RIGHT:   cfg_right_q <= crg_vec3_t'(cfg_wdata_i);
        REG_UP:      cfg_up_q    <= crg_vec3_t'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Pipeline advance; held only while the skid register is occupied.
  logic en;
  logic skid_full_q;

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  // Stage 1: clamp and scale the coordinates
  logic [PIX_X_W-1:0] xc;
  logic [PIX_Y_W-1:0] yc;
  logic [X_PRD_W-1:0] x_prod;
  logic [Y_PRD_W-1:0] y_prod;
  logic               s1_valid_q;
  logic [QF_W-1:0]    s1_qx_q, s1_qy_q;

  always_comb begin
    xc = (32'(in_data_i.pixel_x) >= IMAGE_WIDTH) ? PIX_X_W'(IMAGE_WIDTH - 1)
                                                 : in_data_i.pixel_x;
    yc = (32'(in_data_i.pixel_y) >= IMAGE_HEIGHT) ? PIX_Y_W'(IMAGE_HEIGHT - 1)
                                                  : in_data_i.pixel_y;
    x_prod = X_PRD_W'(xc) * X_PRD_W'(X_RECIP);
    y_prod = Y_PRD_W'(yc) * Y_PRD_W'(Y_RECIP);
  end

  // Stage 2: factor products
  logic signed [FACT_W-1:0] fx, fy;
  logic                     s2_valid_q;
  logic signed [PROD_W-1:0] s2_pr_q [3];
  logic signed [PROD_W-1:0] s2_pu_q [3];

  assign fx = $signed(FACT_W'(s1_qx_q)) - FACT_ONE;
  assign fy = $signed(FACT_W'(s1_qy_q)) - FACT_ONE;

  // Stage 3: direction sum
  logic signed [SUM_W-1:0] fwd_ext [3];
  logic                    s3_valid_q;
  logic signed [SUM_W-1:0] s3_d_q  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fwd_ext[i] = SUM_W'($signed(cfg_fwd_q[i]));
    end
  end

  // Stage 4: sign and magnitude
  logic                  s4_valid_q;
  logic [2:0]            s4_neg_q;
  logic [2:0][MAG_W-1:0] s4_mag_q;

  // Stage 5: normalising shift amount
  logic [MAG_W-1:0]      orv;
  logic [SHAMT_W-1:0]    msb;
  logic [SHAMT_W-1:0]    shamt;
  logic                  s5_valid_q;
  logic [2:0]            s5_neg_q;
  logic                  s5_zero_q;
  logic [SHAMT_W-1:0]    s5_shamt_q;
  logic [2:0][MAG_W-1:0] s5_mag_q;

  // The top set bit of the OR is the top set bit of the largest magnitude.
  always_comb begin
    orv = s4_mag_q[0] | s4_mag_q[1] | s4_mag_q[2];
    msb = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (orv[b]) begin
        msb = SHAMT_W'(b);
      end
    end
    shamt = (msb < SHAMT_W'(NORM_MSB)) ? SHAMT_W'(NORM_MSB) - msb : '0;
  end

  // Stage 6: shifted magnitudes
  logic      s6_valid_q;
  crg_norm_t s6_norm_q;

  // Stage 7: squares
  logic            s7_valid_q;
  crg_norm_t       s7_norm_q;
  logic [SQ_W-1:0] s7_sq_q [3];

  // Stage 8 and 9: sum of squares
  logic              s8_valid_q;
  crg_norm_t         s8_norm_q;
  logic [PSUM_W-1:0] s8_part_q;
  logic [SQ_W-1:0]   s8_sq2_q;
  logic              s9_valid_q;
  crg_norm_t         s9_norm_q;
  logic [RAD_W-1:0]  s9_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
      s9_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
      s7_valid_q <= s6_valid_q;
      s8_valid_q <= s7_valid_q;
      s9_valid_q <= s8_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_qx_q <= QF_W'(x_prod >> X_LSB);
      s1_qy_q <= QF_W'(y_prod >> Y_LSB);

      for (int i = 0; i < 3; i++) begin
        s2_pr_q[i] <= $signed(cfg_right_q[i]) * fx;
        s2_pu_q[i] <= $signed(cfg_up_q[i]) * fy;
        s3_d_q[i]  <= s2_pu_q[i] + s2_pr_q[i] + (fwd_ext[i] <<< FRAC_W);
        s4_neg_q[i] <= s3_d_q[i][SUM_W-1];
        s4_mag_q[i] <= s3_d_q[i][SUM_W-1] ? MAG_W'(-s3_d_q[i]) : MAG_W'(s3_d_q[i]);
        s6_norm_q.mag[i] <= s5_mag_q[i] << s5_shamt_q;
        s7_sq_q[i] <= SQ_W'(s6_norm_q.mag[i]) * SQ_W'(s6_norm_q.mag[i]);
      end

      s5_neg_q   <= s4_neg_q;
      s5_zero_q  <= (orv == '0);
      s5_shamt_q <= shamt;
      s5_mag_q   <= s4_mag_q;

      s6_norm_q.sgn.neg  <= s5_neg_q;
      s6_norm_q.sgn.zero <= s5_zero_q;

      s7_norm_q <= s6_norm_q;

      s8_norm_q <= s7_norm_q;
      s8_part_q <= PSUM_W'(s7_sq_q[0]) + PSUM_W'(s7_sq_q[1]);
      s8_sq2_q  <= s7_sq_q[2];

      s9_norm_q <= s8_norm_q;
      s9_rad_q  <= RAD_W'(s8_part_q) + RAD_W'(s8_sq2_q);
    end
  end

  // Square root of the sum of squares
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  crg_norm_t         sq_norm;

  crg_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s9_valid_q),
    .rad_i   (s9_rad_q),
    .norm_i  (s9_norm_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .norm_o  (sq_norm)
  );

  // Divide each magnitude by the length
  logic                  dv_valid;
  logic [2:0][QUO_W-1:0] dv_quo;
  crg_sign_t             dv_sgn;

  crg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .norm_i  (sq_norm),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .sgn_o   (dv_sgn)
  );

  // Saturate, apply sign, force a zero vector to zero
  logic [QUO_W-1:0]        qs  [3];
  logic signed [DIR_W-1:0] dir [3];
  crg_dir_t                res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i]  = (dv_quo[i] > QUO_MAX) ? QUO_MAX : dv_quo[i];
      dir[i] = dv_sgn.neg[i] ? -$signed(DIR_W'(qs[i])) : $signed(DIR_W'(qs[i]));
      if (dv_sgn.zero) begin
        dir[i] = '0;
      end
    end
    res.dir_x = dir[0];
    res.dir_y = dir[1];
    res.dir_z = dir[2];
  end

  // Output register with skid
  logic     out_valid_q;
  crg_dir_t out_data_q, skid_data_q;
  logic     take, arrive;

  assign take   = out_valid_q && !out_stall_i;
  assign arrive = en && dv_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (take) begin
        skid_full_q <= 1'b0;
      end
    end else if (arrive) begin
      if (out_valid_q && !take) begin
        skid_full_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (take) begin
        out_data_q <= skid_data_q;
      end
    end else if (arrive) begin
      if (out_valid_q && !take) begin
        skid_data_q <= res;
      end else begin
        out_data_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
